// ===== rtl/core/pba_pkg.sv =====
// Shared constants, types and helpers for the page bitmap allocator.
package pba_pkg;

  localparam int NUM_PAGES = 4096;
  localparam int WORD_W    = 64;
  localparam int OFF_W     = $clog2(WORD_W);
  localparam int WORDS     = (NUM_PAGES + WORD_W - 1) / WORD_W;
  localparam int ADDR_W    = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int CNT_W     = $clog2(NUM_PAGES + 1);
  localparam int POS_W     = (CNT_W + 1 > ADDR_W + OFF_W + 1) ? CNT_W + 1 : ADDR_W + OFF_W + 1;

  localparam int OP_W    = 2;
  localparam int PAGE_W  = 12;
  localparam int LEN_W   = 13;
  localparam int FOUND_W = 1;
  localparam int FREE_W  = 13;

  localparam int IN_OP_LSB    = 0;
  localparam int IN_START_LSB = IN_OP_LSB + OP_W;
  localparam int IN_LEN_LSB   = IN_START_LSB + PAGE_W;
  localparam int IN_BITS      = IN_LEN_LSB + LEN_W;
  localparam int IN_DATA_W    = ((IN_BITS + 7) / 8) * 8;

  localparam int OUT_FOUND_LSB = 0;
  localparam int OUT_PAGE_LSB  = OUT_FOUND_LSB + FOUND_W;
  localparam int OUT_FREE_LSB  = OUT_PAGE_LSB + PAGE_W;
  localparam int OUT_BITS      = OUT_FREE_LSB + FREE_W;
  localparam int OUT_DATA_W    = ((OUT_BITS + 7) / 8) * 8;

  typedef enum logic [OP_W-1:0] {
    OP_USE  = 2'd0,
    OP_FREE = 2'd1,
    OP_FIND = 2'd2,
    OP_NONE = 2'd3
  } op_t;

  typedef struct packed {
    logic load;
    logic rd;
    logic mark_wr;
    logic find_hit;
    logic find_next;
    logic find_skip;
    logic out_load;
  } pba_cmd_t;

  typedef struct packed {
    logic go_mark;
    logic go_find;
    logic mark_last;
    logic blk_used;
    logic blk_fit;
    logic skip_over;
    logic skip_same;
    logic out_busy;
  } pba_stat_t;

  function automatic logic [WORD_W-1:0] range_mask(input logic [OFF_W-1:0] lo,
                                                   input logic [OFF_W:0] hi);
    logic [WORD_W-1:0] m;
    m = '0;
    for (int i = 0; i < WORD_W; i++) begin
      m[i] = ((OFF_W+1)'(i) >= {1'b0, lo}) && ((OFF_W+1)'(i) < hi);
    end
    return m;
  endfunction

endpackage

// ===== rtl/core/pba_bitmap.sv =====
// Used-page bitmap memory with per-word valid flags that read as all used.
module pba_bitmap
  import pba_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WORD_W-1:0] rd_data,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WORD_W-1:0] wr_data
);

  logic [WORD_W-1:0] mem [WORDS];
  logic [WORDS-1:0]  vld_r;
  logic [WORD_W-1:0] rd_word_r;
  logic              rd_vld_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_word_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_r <= vld_r[rd_addr];
      end
    end
  end

  assign rd_data = rd_vld_r ? rd_word_r : '1;

endmodule

// ===== rtl/core/pba_datapath.sv =====
// Run bounds, word masks, free-page count and result register.
module pba_datapath
  import pba_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  pba_cmd_t              cmd,
  output pba_stat_t             st,
  output logic                  mem_rd,
  output logic                  mem_wr,
  output logic [ADDR_W-1:0]     mem_addr,
  output logic [WORD_W-1:0]     mem_wdata,
  input  logic [WORD_W-1:0]     mem_rdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata
);

  localparam logic [POS_W-1:0] LIMIT = POS_W'(NUM_PAGES);
  localparam logic [POS_W-1:0] SPAN  = POS_W'(WORD_W);

  logic [OP_W-1:0]   in_op;
  logic [POS_W-1:0]  in_start;
  logic [POS_W-1:0]  in_len;
  logic [POS_W-1:0]  in_end;
  logic [POS_W-1:0]  in_end_clip;

  logic [POS_W-1:0]  s_r, e_r, len_r;
  logic [ADDR_W-1:0] w_r;
  logic              used_r;
  logic              found_r;
  logic [PAGE_W-1:0] fpage_r;
  logic [CNT_W-1:0]  free_r, free_nxt;
  logic              pend_r, pend_dec_r;
  logic [OFF_W:0]    pop_r;
  logic              out_tvalid_r;
  logic [OUT_DATA_W-1:0] out_tdata_r;

  logic [POS_W-1:0]  base, base_end, lo, hi, lo_rel, hi_rel, s_skip, e_skip;
  logic [WORD_W-1:0] mask, chg;

  assign in_op       = in_tdata[IN_OP_LSB +: OP_W];
  assign in_start    = POS_W'(in_tdata[IN_START_LSB +: PAGE_W]);
  assign in_len      = POS_W'(in_tdata[IN_LEN_LSB +: LEN_W]);
  assign in_end      = in_start + in_len;
  assign in_end_clip = (in_end > LIMIT) ? LIMIT : in_end;

  assign st.go_mark = ((in_op == OP_USE) || (in_op == OP_FREE)) && (in_start < in_end_clip);
  assign st.go_find = (in_op == OP_FIND) && (in_len != '0) && (in_len <= LIMIT);

  assign base     = POS_W'({w_r, {OFF_W{1'b0}}});
  assign base_end = base + SPAN;
  assign lo       = (s_r > base) ? s_r : base;
  assign hi       = (e_r < base_end) ? e_r : base_end;
  assign lo_rel   = lo - base;
  assign hi_rel   = hi - base;
  assign mask     = range_mask(lo_rel[OFF_W-1:0], hi_rel[OFF_W:0]);
  assign chg      = used_r ? (mask & ~mem_rdata) : (mask & mem_rdata);
  assign s_skip   = s_r + len_r;
  assign e_skip   = e_r + len_r;

  assign st.mark_last = (e_r <= base_end);
  assign st.blk_used  = |(mem_rdata & mask);
  assign st.blk_fit   = (e_r <= base_end);
  assign st.skip_over = (e_skip > LIMIT);
  assign st.skip_same = (s_skip[OFF_W +: ADDR_W] == w_r);
  assign st.out_busy  = out_tvalid_r && !out_tready;

  assign mem_rd    = cmd.rd;
  assign mem_wr    = cmd.mark_wr;
  assign mem_addr  = w_r;
  assign mem_wdata = used_r ? (mem_rdata | mask) : (mem_rdata & ~mask);

  always_comb begin
    free_nxt = free_r;
    if (pend_r) begin
      free_nxt = pend_dec_r ? (free_r - CNT_W'(pop_r)) : (free_r + CNT_W'(pop_r));
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      used_r  <= (in_op == OP_USE);
      len_r   <= in_len;
      found_r <= 1'b0;
      fpage_r <= '0;
      if (in_op == OP_FIND) begin
        s_r <= '0;
        e_r <= in_len;
        w_r <= '0;
      end else begin
        s_r <= in_start;
        e_r <= in_end_clip;
        w_r <= in_start[OFF_W +: ADDR_W];
      end
    end
    if (cmd.mark_wr) begin
      pop_r      <= (OFF_W+1)'($countones(chg));
      pend_dec_r <= used_r;
      w_r        <= w_r + 1'b1;
    end
    if (cmd.find_next) begin
      w_r <= w_r + 1'b1;
    end
    if (cmd.find_skip) begin
      s_r <= s_skip;
      e_r <= e_skip;
      w_r <= s_skip[OFF_W +: ADDR_W];
    end
    if (cmd.find_hit) begin
      found_r <= 1'b1;
      fpage_r <= s_r[PAGE_W-1:0];
    end
    if (cmd.out_load) begin
      out_tdata_r <= OUT_DATA_W'({FREE_W'(free_nxt), fpage_r, found_r});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      free_r       <= '0;
      pend_r       <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      free_r <= free_nxt;
      pend_r <= cmd.mark_wr;
      if (cmd.out_load) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

endmodule

// ===== rtl/core/pba_ctrl.sv =====
// Request sequencer for marking and searching the bitmap.
module pba_ctrl
  import pba_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_tvalid,
  output logic      in_tready,
  input  pba_stat_t st,
  output pba_cmd_t  cmd
);

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_MRD  = 6'b000010,
    ST_MMOD = 6'b000100,
    ST_FRD  = 6'b001000,
    ST_FCHK = 6'b010000,
    ST_DONE = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  assign in_tready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd.load = 1'b1;
          priority if (st.go_mark) begin
            state_nxt = ST_MRD;
          end else if (st.go_find) begin
            state_nxt = ST_FRD;
          end else begin
            state_nxt = ST_DONE;
          end
        end
      end
      ST_MRD: begin
        cmd.rd    = 1'b1;
        state_nxt = ST_MMOD;
      end
      ST_MMOD: begin
        cmd.mark_wr = 1'b1;
        state_nxt   = st.mark_last ? ST_DONE : ST_MRD;
      end
      ST_FRD: begin
        cmd.rd    = 1'b1;
        state_nxt = ST_FCHK;
      end
      ST_FCHK: begin
        priority if (!st.blk_used && st.blk_fit) begin
          cmd.find_hit = 1'b1;
          state_nxt    = ST_DONE;
        end else if (!st.blk_used) begin
          cmd.find_next = 1'b1;
          state_nxt     = ST_FRD;
        end else if (st.skip_over) begin
          state_nxt = ST_DONE;
        end else begin
          cmd.find_skip = 1'b1;
          state_nxt     = st.skip_same ? ST_FCHK : ST_FRD;
        end
      end
      ST_DONE: begin
        if (!st.out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== rtl/core/page_bitmap_allocator_top.sv =====
// Top level of the page bitmap allocator with aligned first-fit search.
//
//   channel  dir  handshake             word
//   in_      in   in_tvalid/in_tready   op, start_page, run_length
//   out_     out  out_tvalid/out_tready found, found_page, free_pages
//
// Mark: a read and a write per 64-page word touched by the run, plus accept and finish.
// Find: a read and a check per word read, a recheck per start retested in a held word, plus accept and finish.
// One request at a time; the word read-modify-write on the bitmap port sets the pace.
// Reset marks every page used through per-word valid flags; no clearing pass.
// A held result stalls only the finish of the next request, not its acceptance.
module page_bitmap_allocator_top
  import pba_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // op[1:0], start_page[13:2], run_length[26:14]
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata   // found[0], found_page[12:1], free_pages[25:13]
);

  pba_cmd_t          cmd;
  pba_stat_t         st;
  logic              mem_rd;
  logic              mem_wr;
  logic [ADDR_W-1:0] mem_addr;
  logic [WORD_W-1:0] mem_wdata;
  logic [WORD_W-1:0] mem_rdata;

  pba_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .st        (st),
    .cmd       (cmd)
  );

  pba_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .cmd        (cmd),
    .st         (st),
    .mem_rd     (mem_rd),
    .mem_wr     (mem_wr),
    .mem_addr   (mem_addr),
    .mem_wdata  (mem_wdata),
    .mem_rdata  (mem_rdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  pba_bitmap u_map (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (mem_rd),
    .rd_addr (mem_addr),
    .rd_data (mem_rdata),
    .wr_en   (mem_wr),
    .wr_addr (mem_addr),
    .wr_data (mem_wdata)
  );

endmodule
